// ===== src/vfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// vfsp_pkg: shared types and constants of the frame slot pool
// Item layouts, operation and status codes, and slot update commands.
// ----------------------------------------------------------------------------
package vfsp_pkg;

  // default sizing
  localparam int SlotCountDef  = 8;
  localparam int OrderWidthDef = 32;
  localparam int TimeW         = 32;
  localparam int SlotW         = 3;

  // operation codes carried in the op field
  typedef enum logic [1:0] {
    OP_STORE   = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_OVERWRITE = 3'd1,
    STAT_NONE_RDY  = 3'd2,
    STAT_NO_FREE   = 3'd3,
    STAT_BAD       = 3'd4
  } status_e;

  // slot update broadcast to the cell row
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_STORE   = 2'd1,
    CMD_ACQUIRE = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  // input item
  typedef struct packed {
    logic [1:0]              op;
    logic signed [TimeW-1:0] frame_time;
    logic [SlotW-1:0]        slot_in;
  } req_t;

  // result item
  typedef struct packed {
    logic [2:0]              status;
    logic [SlotW-1:0]        slot_out;
    logic signed [TimeW-1:0] time_out;
  } rsp_t;

endpackage

// ===== src/vfsp_cell.sv =====
// ----------------------------------------------------------------------------
// vfsp_cell: one slot of the frame slot pool
// Holds the slot state and folds it into the running best candidates that
// travel down the row, one cell per cycle.
// ----------------------------------------------------------------------------
module vfsp_cell #(
  parameter int CELL_IDX    = 0,
  parameter int IDX_W       = 3,
  parameter int ORDER_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // update command
  input  vfsp_pkg::cmd_e               cmd_i,
  input  logic [IDX_W-1:0]             cmd_idx_i,
  input  logic signed [31:0]           cmd_time_i,
  input  logic [ORDER_WIDTH-1:0]       cmd_order_i,
  // scan keys
  input  logic signed [31:0]           last_time_i,
  input  logic [2:0]                   rel_idx_i,
  // candidates from the left neighbor
  input  logic                         free_vld_i,
  input  logic [IDX_W-1:0]             free_idx_i,
  input  logic [ORDER_WIDTH-1:0]       free_ord_i,
  input  logic                         rdy_vld_i,
  input  logic [IDX_W-1:0]             rdy_idx_i,
  input  logic [ORDER_WIDTH-1:0]       rdy_ord_i,
  input  logic                         acq_vld_i,
  input  logic [IDX_W-1:0]             acq_idx_i,
  input  logic signed [31:0]           acq_time_i,
  input  logic                         rel_hit_i,
  input  logic                         rel_held_i,
  input  logic signed [31:0]           rel_time_i,
  // candidates to the right neighbor
  output logic                         free_vld_o,
  output logic [IDX_W-1:0]             free_idx_o,
  output logic [ORDER_WIDTH-1:0]       free_ord_o,
  output logic                         rdy_vld_o,
  output logic [IDX_W-1:0]             rdy_idx_o,
  output logic [ORDER_WIDTH-1:0]       rdy_ord_o,
  output logic                         acq_vld_o,
  output logic [IDX_W-1:0]             acq_idx_o,
  output logic signed [31:0]           acq_time_o,
  output logic                         rel_hit_o,
  output logic                         rel_held_o,
  output logic signed [31:0]           rel_time_o
);
  import vfsp_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [ORDER_WIDTH-1:0] order_q;
  logic                   ready_q;
  logic signed [31:0]     time_q;

  logic free_take, rdy_take, acq_take, rel_match;

  // slot state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_WIDTH'(1);
      ready_q <= 1'b0;
      time_q  <= '0;
    end else if (cmd_idx_i == MyIdx) begin
      unique case (cmd_i)
        CMD_STORE: begin
          time_q  <= cmd_time_i;
          ready_q <= 1'b1;
        end
        CMD_ACQUIRE: begin
          order_q <= '0;
          ready_q <= 1'b0;
        end
        CMD_RELEASE: order_q <= cmd_order_i;
        default: ;
      endcase
    end
  end

  // strict compares keep the lower index on ties
  always_comb begin
    free_take = (order_q != '0) && !ready_q && (!free_vld_i || order_q < free_ord_i);
    rdy_take  = (order_q != '0) && ready_q && (!rdy_vld_i || order_q < rdy_ord_i);
    acq_take  = ready_q && (time_q > last_time_i) && (!acq_vld_i || time_q < acq_time_i);
    rel_match = (int'(rel_idx_i) == CELL_IDX);
  end

  // hand candidates to the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_vld_o <= 1'b0;
      rdy_vld_o  <= 1'b0;
      acq_vld_o  <= 1'b0;
      rel_hit_o  <= 1'b0;
      rel_held_o <= 1'b0;
      free_idx_o <= '0;
      free_ord_o <= '0;
      rdy_idx_o  <= '0;
      rdy_ord_o  <= '0;
      acq_idx_o  <= '0;
      acq_time_o <= '0;
      rel_time_o <= '0;
    end else begin
      free_vld_o <= free_vld_i || free_take;
      free_idx_o <= free_take ? MyIdx : free_idx_i;
      free_ord_o <= free_take ? order_q : free_ord_i;
      rdy_vld_o  <= rdy_vld_i || rdy_take;
      rdy_idx_o  <= rdy_take ? MyIdx : rdy_idx_i;
      rdy_ord_o  <= rdy_take ? order_q : rdy_ord_i;
      acq_vld_o  <= acq_vld_i || acq_take;
      acq_idx_o  <= acq_take ? MyIdx : acq_idx_i;
      acq_time_o <= acq_take ? time_q : acq_time_i;
      rel_hit_o  <= rel_hit_i || rel_match;
      rel_held_o <= rel_match ? (order_q == '0) : rel_held_i;
      rel_time_o <= rel_match ? time_q : rel_time_i;
    end
  end

endmodule

// ===== src/video_frame_slot_pool.sv =====
// ----------------------------------------------------------------------------
// video_frame_slot_pool: pool of decoded-frame slots
// Store, acquire and release of frame slots; a row of slot cells finds the
// lowest-order and earliest-frame candidates, then at most one slot is updated.
// ----------------------------------------------------------------------------
//  channel   | signals                 | direction | handshake
//  ----------+-------------------------+-----------+-------------------------
//  request   | start_i, busy_o, req_i  | in        | taken when start_i & !busy_o
//  result    | rsp_valid_o, rsp_o      | out       | one-cycle strobe, no stall
//
//  From acceptance, the candidates walk the cell row one slot per cycle in
//  the scan state; the commit state then updates at most one slot and
//  registers the result. busy_o is high through scan and commit; the next
//  item can be taken in the strobe cycle.
//  Reset puts every slot free with order one and no frame ready.
//  The result cannot be stalled and is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module video_frame_slot_pool #(
  parameter int SLOT_COUNT  = vfsp_pkg::SlotCountDef,
  parameter int ORDER_WIDTH = vfsp_pkg::OrderWidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  vfsp_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output vfsp_pkg::rsp_t rsp_o
);
  import vfsp_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);

  // candidate chain, one tap per cell boundary
  logic                   free_vld [SLOT_COUNT+1];
  logic [IDX_W-1:0]       free_idx [SLOT_COUNT+1];
  logic [ORDER_WIDTH-1:0] free_ord [SLOT_COUNT+1];
  logic                   rdy_vld  [SLOT_COUNT+1];
  logic [IDX_W-1:0]       rdy_idx  [SLOT_COUNT+1];
  logic [ORDER_WIDTH-1:0] rdy_ord  [SLOT_COUNT+1];
  logic                   acq_vld  [SLOT_COUNT+1];
  logic [IDX_W-1:0]       acq_idx  [SLOT_COUNT+1];
  logic signed [31:0]     acq_time [SLOT_COUNT+1];
  logic                   rel_hit  [SLOT_COUNT+1];
  logic                   rel_held [SLOT_COUNT+1];
  logic signed [31:0]     rel_time [SLOT_COUNT+1];

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       cnt_q, cnt_d;
  req_t                   req_q;
  logic [ORDER_WIDTH-1:0] ord_cnt_q, ord_cnt_d, ord_cnt_inc;
  logic signed [31:0]     last_q, last_d;
  logic                   rsp_valid_q, rsp_valid_d;
  rsp_t                   rsp_q, rsp_d;

  cmd_e                   cmd;
  logic [IDX_W-1:0]       cmd_idx;
  logic signed [31:0]     cmd_time;
  logic [ORDER_WIDTH-1:0] cmd_order;
  logic [IDX_W+2:0]       slot_ext;
  logic [IDX_W+2:0]       rel_ext;

  // empty candidates enter the head of the row
  assign free_vld[0] = 1'b0;
  assign free_idx[0] = '0;
  assign free_ord[0] = '0;
  assign rdy_vld[0]  = 1'b0;
  assign rdy_idx[0]  = '0;
  assign rdy_ord[0]  = '0;
  assign acq_vld[0]  = 1'b0;
  assign acq_idx[0]  = '0;
  assign acq_time[0] = '0;
  assign rel_hit[0]  = 1'b0;
  assign rel_held[0] = 1'b0;
  assign rel_time[0] = '0;

  // row of slot cells
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    vfsp_cell #(
      .CELL_IDX    (g),
      .IDX_W       (IDX_W),
      .ORDER_WIDTH (ORDER_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .cmd_idx_i   (cmd_idx),
      .cmd_time_i  (cmd_time),
      .cmd_order_i (cmd_order),
      .last_time_i (last_q),
      .rel_idx_i   (req_q.slot_in),
      .free_vld_i  (free_vld[g]),
      .free_idx_i  (free_idx[g]),
      .free_ord_i  (free_ord[g]),
      .rdy_vld_i   (rdy_vld[g]),
      .rdy_idx_i   (rdy_idx[g]),
      .rdy_ord_i   (rdy_ord[g]),
      .acq_vld_i   (acq_vld[g]),
      .acq_idx_i   (acq_idx[g]),
      .acq_time_i  (acq_time[g]),
      .rel_hit_i   (rel_hit[g]),
      .rel_held_i  (rel_held[g]),
      .rel_time_i  (rel_time[g]),
      .free_vld_o  (free_vld[g+1]),
      .free_idx_o  (free_idx[g+1]),
      .free_ord_o  (free_ord[g+1]),
      .rdy_vld_o   (rdy_vld[g+1]),
      .rdy_idx_o   (rdy_idx[g+1]),
      .rdy_ord_o   (rdy_ord[g+1]),
      .acq_vld_o   (acq_vld[g+1]),
      .acq_idx_o   (acq_idx[g+1]),
      .acq_time_o  (acq_time[g+1]),
      .rel_hit_o   (rel_hit[g+1]),
      .rel_held_o  (rel_held[g+1]),
      .rel_time_o  (rel_time[g+1])
    );
  end

  // saturating release order
  assign ord_cnt_inc = (&ord_cnt_q) ? ord_cnt_q : ord_cnt_q + ORDER_WIDTH'(1);
  assign rel_ext     = {IDX_W'(0), req_q.slot_in};

  // sequencer and slot decision
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ord_cnt_d   = ord_cnt_q;
    last_d      = last_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    cmd         = CMD_NONE;
    cmd_idx     = '0;
    cmd_time    = req_q.frame_time;
    cmd_order   = ord_cnt_inc;
    slot_ext    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(SLOT_COUNT - 1)) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        state_d     = S_IDLE;
        rsp_valid_d = 1'b1;
        unique case (req_q.op)
          OP_STORE: begin
            rsp_d.time_out = req_q.frame_time;
            if (free_vld[SLOT_COUNT]) begin
              cmd          = CMD_STORE;
              cmd_idx      = free_idx[SLOT_COUNT];
              rsp_d.status = STAT_OK;
            end else if (rdy_vld[SLOT_COUNT]) begin
              cmd          = CMD_STORE;
              cmd_idx      = rdy_idx[SLOT_COUNT];
              rsp_d.status = STAT_OVERWRITE;
            end else begin
              rsp_d.status = STAT_NO_FREE;
            end
            slot_ext       = {3'b000, cmd_idx};
            rsp_d.slot_out = slot_ext[2:0];
          end
          OP_ACQUIRE: begin
            if (acq_vld[SLOT_COUNT]) begin
              cmd            = CMD_ACQUIRE;
              cmd_idx        = acq_idx[SLOT_COUNT];
              last_d         = acq_time[SLOT_COUNT];
              rsp_d.status   = STAT_OK;
              rsp_d.time_out = acq_time[SLOT_COUNT];
            end else begin
              rsp_d.status   = STAT_NONE_RDY;
              rsp_d.time_out = '0;
            end
            slot_ext       = {3'b000, cmd_idx};
            rsp_d.slot_out = slot_ext[2:0];
          end
          OP_RELEASE: begin
            rsp_d.slot_out = req_q.slot_in;
            if (!rel_hit[SLOT_COUNT]) begin
              rsp_d.status   = STAT_BAD;
              rsp_d.time_out = '0;
            end else if (!rel_held[SLOT_COUNT]) begin
              rsp_d.status   = STAT_BAD;
              rsp_d.time_out = rel_time[SLOT_COUNT];
            end else begin
              cmd            = CMD_RELEASE;
              cmd_idx        = rel_ext[IDX_W-1:0];
              ord_cnt_d      = ord_cnt_inc;
              rsp_d.status   = STAT_OK;
              rsp_d.time_out = rel_time[SLOT_COUNT];
            end
          end
          default: begin
            rsp_d.status   = STAT_BAD;
            rsp_d.slot_out = '0;
            rsp_d.time_out = '0;
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ord_cnt_q   <= ORDER_WIDTH'(1);
      last_q      <= -32'sd1;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ord_cnt_q   <= ord_cnt_d;
      last_q      <= last_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) req_q <= req_i;
    rsp_q <= rsp_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // checks
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("controller state not one-hot");

  a_strobe_after_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(state_q == S_COMMIT)) else $error("result without update");

  a_accept_starts_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_SCAN && cnt_q == '0))
    else $error("accepted item did not start a scan");

  a_overwrite_only_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == STAT_OVERWRITE) |-> (req_q.op == OP_STORE))
    else $error("overwrite flagged on a non-store item");

endmodule
